// File: hdl/mtfq_pkg.sv
`default_nettype none

package mtfq_pkg;

	// Fixed widths of the word fields
	localparam int DATA_WIDTH = 32;
	localparam int COUNT_W    = 5;
	localparam int DEPTH_DEF  = 16;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	// Largest signed value, reported as the minimum of an empty queue
	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_XFER,
		ST_POPRD,
		ST_RESP
	} state_e;

	// Input word
	typedef struct packed {
		logic [1:0] command;
		data_t      value;
	} in_word_t;

	// Result word
	typedef struct packed {
		data_t              front_value;
		data_t              min_value;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic [1:0]         error_code;
	} out_word_t;

	// One stack entry: value and minimum of itself and all entries below
	typedef struct packed {
		data_t val;
		data_t mn;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture the accepted word, clear error
		logic push;      // write onto the input stack
		logic set_full;  // flag push while full
		logic set_empty; // flag pop while empty
		logic pop;       // drop output top, fetch the next one
		logic pop_fill;  // load fetched entry into the top cache
		logic xfer_rd;   // move one input entry toward the output stack
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_push;
		logic is_pop;
		logic full;
		logic in_empty;
		logic out_empty;
		logic out_multi;
	} dp_sts_t;

	function automatic data_t smin(input data_t a, input data_t b);
		return (a <= b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mtfq_ctrl.sv
`default_nettype none

module mtfq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire mtfq_pkg::dp_sts_t sts,
	output mtfq_pkg::dp_cmd_t      cmd
);

	mtfq_pkg::state_e state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtfq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mtfq_pkg::ST_IDLE: begin
				if (start) state_nxt = mtfq_pkg::ST_EXEC;
			end
			mtfq_pkg::ST_EXEC: begin
				priority if (sts.is_push) begin
					state_nxt = mtfq_pkg::ST_RESP;
				end else if (sts.out_empty && !sts.in_empty) begin
					state_nxt = mtfq_pkg::ST_XFER;
				end else if (sts.is_pop && sts.out_multi) begin
					state_nxt = mtfq_pkg::ST_POPRD;
				end else begin
					state_nxt = mtfq_pkg::ST_RESP;
				end
			end
			// last pending write lands at the same edge that leaves this state
			mtfq_pkg::ST_XFER: begin
				if (sts.in_empty) state_nxt = mtfq_pkg::ST_EXEC;
			end
			mtfq_pkg::ST_POPRD: begin
				state_nxt = mtfq_pkg::ST_RESP;
			end
			mtfq_pkg::ST_RESP: begin
				state_nxt = start ? mtfq_pkg::ST_EXEC : mtfq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = mtfq_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			mtfq_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			mtfq_pkg::ST_EXEC: begin
				priority if (sts.is_push) begin
					if (sts.full) cmd.set_full = 1'b1;
					else          cmd.push     = 1'b1;
				end else if (sts.out_empty && !sts.in_empty) begin
					cmd.xfer_rd = 1'b1;
				end else if (sts.is_pop) begin
					if (sts.out_empty) cmd.set_empty = 1'b1;
					else               cmd.pop       = 1'b1;
				end else begin
					cmd.pop = 1'b0;
				end
			end
			mtfq_pkg::ST_XFER: begin
				cmd.xfer_rd = !sts.in_empty;
			end
			mtfq_pkg::ST_POPRD: begin
				cmd.pop_fill = 1'b1;
			end
			mtfq_pkg::ST_RESP: begin
				busy = 1'b0;
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
		cmd.load = start && !busy;
	end

endmodule

`default_nettype wire

// File: hdl/mtfq_dp.sv
`default_nettype none

module mtfq_dp #(
	parameter int DEPTH = mtfq_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mtfq_pkg::in_word_t item,
	input  wire mtfq_pkg::dp_cmd_t  cmd,
	output mtfq_pkg::dp_sts_t       sts,
	output mtfq_pkg::out_word_t     result
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CntW = mtfq_pkg::COUNT_W;

	// Stack storage
	mtfq_pkg::entry_t in_mem  [DEPTH];
	mtfq_pkg::entry_t out_mem [DEPTH];

	logic [1:0]        cmd_q;
	mtfq_pkg::data_t   val_q;
	mtfq_pkg::err_e    err_q;
	logic [CW-1:0]     in_count_q, out_count_q;
	mtfq_pkg::data_t   in_min_q, out_min_q;
	mtfq_pkg::data_t   in_bottom_q, out_top_q;
	mtfq_pkg::entry_t  in_rd_q, out_rd_q;
	logic              wr_pend_s1;

	logic [CW-1:0]     in_dec, out_dec, out_dec2;
	logic [CW:0]       total;
	mtfq_pkg::data_t   push_min, xfer_min;

	assign in_dec   = in_count_q - CW'(1);
	assign out_dec  = out_count_q - CW'(1);
	assign out_dec2 = out_count_q - CW'(2);
	assign total    = {1'b0, in_count_q} + {1'b0, out_count_q};
	assign push_min = mtfq_pkg::smin(val_q, in_min_q);
	assign xfer_min = mtfq_pkg::smin(in_rd_q.val, out_min_q);

	// Accepted word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= item.command;
			val_q <= item.value;
		end
	end

	// Input stack memory: push write, transfer read
	always_ff @(posedge clk) begin
		if (cmd.push) in_mem[in_count_q[AW-1:0]] <= '{val: val_q, mn: push_min};
		if (cmd.xfer_rd) in_rd_q <= in_mem[in_dec[AW-1:0]];
	end

	// Output stack memory: transfer write, read of the entry under the top
	always_ff @(posedge clk) begin
		if (wr_pend_s1) out_mem[out_count_q[AW-1:0]] <= '{val: in_rd_q.val, mn: xfer_min};
		if (cmd.pop) out_rd_q <= out_mem[out_dec2[AW-1:0]];
	end

	// Bottom of the input stack, used as the front while the output stack is empty
	always_ff @(posedge clk) begin
		if (cmd.push && in_count_q == '0) in_bottom_q <= val_q;
	end

	// Cached top value of the output stack
	always_ff @(posedge clk) begin
		if (wr_pend_s1)    out_top_q <= in_rd_q.val;
		else if (cmd.pop_fill) out_top_q <= out_rd_q.val;
	end

	// Fill levels, running minima, error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= '0;
			out_count_q <= '0;
			in_min_q    <= mtfq_pkg::DATA_MAX;
			out_min_q   <= mtfq_pkg::DATA_MAX;
			err_q       <= mtfq_pkg::ERR_NONE;
			wr_pend_s1  <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.xfer_rd;

			if (cmd.load)           err_q <= mtfq_pkg::ERR_NONE;
			else if (cmd.set_full)  err_q <= mtfq_pkg::ERR_FULL;
			else if (cmd.set_empty) err_q <= mtfq_pkg::ERR_EMPTY;

			// input stack
			if (cmd.push) begin
				in_count_q <= in_count_q + CW'(1);
				in_min_q   <= push_min;
			end else if (cmd.xfer_rd) begin
				in_count_q <= in_dec;
				if (in_count_q == CW'(1)) in_min_q <= mtfq_pkg::DATA_MAX;
			end

			// output stack
			if (wr_pend_s1) begin
				out_count_q <= out_count_q + CW'(1);
				out_min_q   <= xfer_min;
			end else if (cmd.pop) begin
				out_count_q <= out_dec;
				if (out_count_q == CW'(1)) out_min_q <= mtfq_pkg::DATA_MAX;
			end else if (cmd.pop_fill) begin
				out_min_q <= out_rd_q.mn;
			end
		end
	end

	// Status toward the controller
	always_comb begin
		sts.is_push   = (cmd_q == mtfq_pkg::CMD_PUSH);
		sts.is_pop    = (cmd_q == mtfq_pkg::CMD_POP);
		sts.full      = (total >= (CW+1)'(DEPTH));
		sts.in_empty  = (in_count_q == '0);
		sts.out_empty = (out_count_q == '0);
		sts.out_multi = (out_count_q > CW'(1));
	end

	// Result word from the cached state
	always_comb begin
		if (out_count_q != '0)     result.front_value = out_top_q;
		else if (in_count_q != '0) result.front_value = in_bottom_q;
		else                       result.front_value = '0;
		result.min_value  = mtfq_pkg::smin(in_min_q, out_min_q);
		result.count      = CntW'(total);
		result.is_empty   = (total == '0);
		result.error_code = err_q;
	end

endmodule

`default_nettype wire

// File: hdl/min_tracking_fifo_two_stack_unit.sv
`default_nettype none

// Minimum-tracking FIFO of signed words, built from an input and an output stack.
// Input channel: item (command and value) is taken at a clock edge where start is
// high and busy is low. Result channel: result is valid for the one cycle in which
// done is high; the receiver cannot stall it and must take it in that cycle.
// Each result carries the oldest value, the minimum of all held values, the fill
// count, an empty flag and an error code.
// Sequence from the accepting edge: push, peek and pop that need no transfer run
// in ST_EXEC and show done in ST_RESP; a pop that leaves the output stack non-empty
// first passes ST_POPRD to fetch the new top from the output stack memory.
// A pop or peek that finds the output stack empty first moves the input stack over,
// one entry per cycle through the single memory read port. A new item may be accepted
// in the cycle where done is high.
// Reset empties both stacks at once; stack memory is not cleared.

module min_tracking_fifo_two_stack_unit #(
	parameter int DEPTH = mtfq_pkg::DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire mtfq_pkg::in_word_t  item,
	output logic                     done,
	output mtfq_pkg::out_word_t      result
);

	mtfq_pkg::dp_cmd_t dp_cmd;
	mtfq_pkg::dp_sts_t dp_sts;

	mtfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (dp_sts),
		.cmd    (dp_cmd)
	);

	mtfq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (dp_cmd),
		.sts    (dp_sts),
		.result (result)
	);

endmodule

`default_nettype wire

// File: hdl/mtfq_checker.sv
`default_nettype none

module mtfq_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire mtfq_pkg::out_word_t result
);

	// a result cycle is also a cycle that takes new words
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// accepted word always goes through a working state before its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("no working cycle after accept");

	// an empty queue reports zero front, zero count and the largest value as minimum
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |->
			(result.count == '0 && result.front_value == '0
			 && result.min_value == mtfq_pkg::DATA_MAX))
		else $error("bad empty result");

	// a dropped push means the queue holds values; a failed pop means it holds none
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.error_code != mtfq_pkg::ERR_FULL || !result.is_empty)
			&& (result.error_code != mtfq_pkg::ERR_EMPTY || result.is_empty)))
		else $error("error code disagrees with fill");

	// the minimum never exceeds the front value
	a_min_front: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.is_empty) |-> (result.min_value <= result.front_value))
		else $error("minimum above front");

endmodule

bind min_tracking_fifo_two_stack_unit mtfq_checker u_mtfq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

// File: sim/min_tracking_fifo_two_stack_unit_tb.sv
`default_nettype none

module min_tracking_fifo_two_stack_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = mtfq_pkg::DEPTH_DEF;
	localparam int RANDOM_WORDS = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int REPORT_CAP = 40;

	// Command code with no meaning of its own, handled as a peek
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam mtfq_pkg::data_t DATA_MIN = ~mtfq_pkg::DATA_MAX;

	// One line of the directed plan; res is used only when known is set
	typedef struct {
		logic [1:0]          cmd;
		mtfq_pkg::data_t     val;
		int                  reps;
		bit                  known;
		mtfq_pkg::out_word_t res;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	mtfq_pkg::in_word_t  item = '0;
	logic                busy;
	logic                done;
	mtfq_pkg::out_word_t result;

	// Queue model: both stacks with their running minimums
	mtfq_pkg::data_t in_val[DEPTH];
	mtfq_pkg::data_t in_low[DEPTH];
	mtfq_pkg::data_t out_val[DEPTH];
	mtfq_pkg::data_t out_low[DEPTH];
	int    in_fill = 0;
	int    out_fill = 0;

	mtfq_pkg::out_word_t pending_results[$];
	plan_row_t           plan[$];
	int                  mismatches = 0;
	int                  cycles = 0;
	bit                  pace_gaps = 1'b1;

	min_tracking_fifo_two_stack_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #6 clk = ~clk;

	function automatic mtfq_pkg::data_t lesser(input mtfq_pkg::data_t a,
			input mtfq_pkg::data_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic mtfq_pkg::data_t in_floor();
		return (in_fill != 0) ? in_low[in_fill-1] : mtfq_pkg::DATA_MAX;
	endfunction

	function automatic mtfq_pkg::data_t out_floor();
		return (out_fill != 0) ? out_low[out_fill-1] : mtfq_pkg::DATA_MAX;
	endfunction

	// Advance the queue model by one command word and form its result
	task automatic run_queue_model(input mtfq_pkg::in_word_t w,
			output mtfq_pkg::out_word_t r);
		logic [1:0]      err;
		mtfq_pkg::data_t v;
		int              total;
		err = mtfq_pkg::ERR_NONE;
		// pop and peek refill the output stack when it has run dry
		if (w.command != mtfq_pkg::CMD_PUSH && out_fill == 0) begin
			while (in_fill != 0 && out_fill < DEPTH) begin
				v = in_val[in_fill-1];
				in_fill--;
				out_low[out_fill] = lesser(v, out_floor());
				out_val[out_fill] = v;
				out_fill++;
			end
		end
		case (w.command)
			mtfq_pkg::CMD_PUSH: begin
				if (in_fill + out_fill >= DEPTH) begin
					err = mtfq_pkg::ERR_FULL;
				end else begin
					in_low[in_fill] = lesser(w.value, in_floor());
					in_val[in_fill] = w.value;
					in_fill++;
				end
			end
			mtfq_pkg::CMD_POP: begin
				if (out_fill == 0)
					err = mtfq_pkg::ERR_EMPTY;
				else
					out_fill--;
			end
			default: ;
		endcase
		total = in_fill + out_fill;
		if (out_fill != 0)
			r.front_value = out_val[out_fill-1];
		else if (in_fill != 0)
			r.front_value = in_val[0];
		else
			r.front_value = '0;
		r.min_value = lesser(in_floor(), out_floor());
		r.count = total[mtfq_pkg::COUNT_W-1:0];
		r.is_empty = (total == 0);
		r.error_code = err;
	endtask

	function automatic plan_row_t plan_word(input logic [1:0] cmd,
			input mtfq_pkg::data_t val, input int reps = 1);
		plan_row_t p;
		p.cmd = cmd;
		p.val = val;
		p.reps = reps;
		p.known = 1'b0;
		p.res = '0;
		return p;
	endfunction

	function automatic plan_row_t plan_known(input logic [1:0] cmd,
			input mtfq_pkg::data_t val, input mtfq_pkg::data_t fr,
			input mtfq_pkg::data_t mn, input int cnt, input logic [1:0] err);
		plan_row_t p;
		p = plan_word(cmd, val);
		p.known = 1'b1;
		p.res.front_value = fr;
		p.res.min_value = mn;
		p.res.count = cnt[mtfq_pkg::COUNT_W-1:0];
		p.res.is_empty = (cnt == 0);
		p.res.error_code = err;
		return p;
	endfunction

	function automatic mtfq_pkg::data_t pick_value();
		case ($urandom_range(0, 9))
			0: return DATA_MIN;
			1: return mtfq_pkg::DATA_MAX;
			2: return '0;
			3: return '1;
			4, 5, 6: return mtfq_pkg::data_t'($urandom_range(0, 40)) - mtfq_pkg::data_t'(20);
			default: return mtfq_pkg::data_t'($urandom);
		endcase
	endfunction

	// Hold the word on the port until the block takes it, then maybe idle
	task automatic send_word(input mtfq_pkg::in_word_t w, input bit known,
			input mtfq_pkg::out_word_t known_res);
		mtfq_pkg::out_word_t r;
		int                  gap;
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		run_queue_model(w, r);
		pending_results.push_back(known ? known_res : r);
		gap = 0;
		if (pace_gaps && $urandom_range(0, 2) != 0)
			gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (gap != 0) begin
			start <= 1'b0;
			item <= {2'($urandom_range(0, 3)), mtfq_pkg::data_t'($urandom)};
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void check_field(input string name, input longint expv,
			input longint actv);
		if (expv != actv) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
		end
	endfunction

	// Result checker: every strobed word against the oldest expectation
	always @(posedge clk) begin
		mtfq_pkg::out_word_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: unexpected result word, expected none, actual front %0d",
						$time, result.front_value);
			end else begin
				e = pending_results.pop_front();
				check_field("front_value", e.front_value, result.front_value);
				check_field("min_value", e.min_value, result.min_value);
				check_field("count", e.count, result.count);
				check_field("is_empty", e.is_empty, result.is_empty);
				check_field("error_code", e.error_code, result.error_code);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL min_tracking_fifo_two_stack_unit");
			$finish;
		end
	end

	initial begin
		mtfq_pkg::in_word_t  w;
		mtfq_pkg::out_word_t none;
		int                  push_pct;
		int                  sel;
		none = '0;

		// Directed plan: empty-queue corners, extremes, transfer, full and command three
		plan.push_back(plan_known(mtfq_pkg::CMD_PEEK, '0, '0, mtfq_pkg::DATA_MAX, 0,
			mtfq_pkg::ERR_NONE));
		plan.push_back(plan_known(mtfq_pkg::CMD_POP, '0, '0, mtfq_pkg::DATA_MAX, 0,
			mtfq_pkg::ERR_EMPTY));
		plan.push_back(plan_known(CMD_SPARE, '0, '0, mtfq_pkg::DATA_MAX, 0,
			mtfq_pkg::ERR_NONE));
		plan.push_back(plan_known(mtfq_pkg::CMD_PUSH, DATA_MIN, DATA_MIN, DATA_MIN, 1,
			mtfq_pkg::ERR_NONE));
		plan.push_back(plan_word(mtfq_pkg::CMD_PUSH, mtfq_pkg::DATA_MAX));
		plan.push_back(plan_word(mtfq_pkg::CMD_PUSH, '0));
		plan.push_back(plan_word(mtfq_pkg::CMD_PEEK, '1));
		plan.push_back(plan_word(mtfq_pkg::CMD_PUSH, '1));
		plan.push_back(plan_word(mtfq_pkg::CMD_PUSH, mtfq_pkg::data_t'(7), DEPTH - 4));
		plan.push_back(plan_known(mtfq_pkg::CMD_PUSH, mtfq_pkg::data_t'(1), DATA_MIN,
			DATA_MIN, DEPTH, mtfq_pkg::ERR_FULL));
		plan.push_back(plan_word(mtfq_pkg::CMD_POP, '0, 4));
		plan.push_back(plan_word(CMD_SPARE, mtfq_pkg::DATA_MAX));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				w.command = plan[i].cmd;
				w.value = plan[i].val;
				send_word(w, plan[i].known, plan[i].res);
			end
		end

		// Random part: stretches with a push bias sweep the queue between empty and full
		push_pct = 50;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 4))
					0: push_pct = 10;
					1: push_pct = 30;
					2: push_pct = 50;
					3: push_pct = 70;
					default: push_pct = 90;
				endcase
				pace_gaps = ($urandom_range(0, 3) != 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < push_pct) begin
				w.command = mtfq_pkg::CMD_PUSH;
			end else begin
				sel = $urandom_range(0, 9);
				w.command = (sel < 7) ? mtfq_pkg::CMD_POP :
					(sel < 9) ? mtfq_pkg::CMD_PEEK : CMD_SPARE;
			end
			w.value = pick_value();
			send_word(w, 1'b0, none);
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS min_tracking_fifo_two_stack_unit");
		else
			$display("FAIL min_tracking_fifo_two_stack_unit");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/mtfq_pkg.sv
hdl/mtfq_ctrl.sv
hdl/mtfq_dp.sv
hdl/min_tracking_fifo_two_stack_unit.sv
hdl/mtfq_checker.sv
sim/min_tracking_fifo_two_stack_unit_tb.sv
